@@ src/ptc_pkg.sv @@
// shared types and constants for the packet tag cam
package ptc_pkg;

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int PTR_W  = 6;
    localparam int POS_W  = 6;

    // default number of tag slots
    localparam int DEF_NUM_TAGS = 16;

    // buffer depth; positions wrap modulo this value
    localparam int C_BUFFER_DEPTH = 64;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOOKUP     = 2'd0,
        CMD_SET_TAG    = 2'd1,
        CMD_INVALIDATE = 2'd2
    } t_cmd;

    // one beat travelling down the cell chain
    typedef struct packed {
        logic              vld;
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [PTR_W-1:0]  ptr;
        logic              hit;
        logic [PTR_W-1:0]  index;
    } t_beat;

endpackage

@@ src/ptc_cell.sv @@
// one tag slot of the cam chain with its pipeline stage register
module ptc_cell #(
    parameter int CELL_ID = 0,
    parameter int SLOT_W  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  ptc_pkg::t_beat       i_beat,
    input  logic [SLOT_W-1:0]    i_slot,
    output ptc_pkg::t_beat       o_beat,
    output logic [SLOT_W-1:0]    o_slot
);
    import ptc_pkg::*;

    logic              r_tag_vld;
    logic              n_tag_vld;
    logic [ADDR_W-1:0] r_tag_addr;
    logic [ADDR_W-1:0] n_tag_addr;
    logic [PTR_W-1:0]  r_tag_ptr;
    logic [PTR_W-1:0]  n_tag_ptr;
    t_beat             r_beat;
    t_beat             n_beat;
    logic [SLOT_W-1:0] r_slot;
    logic              w_match;

    // lookup: first valid matching slot along the chain wins
    always_comb begin
        w_match = i_beat.vld && (i_beat.cmd == CMD_LOOKUP) && !i_beat.hit
                  && r_tag_vld && (r_tag_addr == i_beat.addr);
        n_beat = i_beat;
        if (w_match) begin
            n_beat.hit   = 1'b1;
            n_beat.index = r_tag_ptr;
        end
    end

    // slot update for set tag and invalidate
    always_comb begin
        n_tag_vld  = r_tag_vld;
        n_tag_addr = r_tag_addr;
        n_tag_ptr  = r_tag_ptr;
        if (i_beat.vld) begin
            case (i_beat.cmd)
                CMD_SET_TAG: begin
                    if (i_slot == SLOT_W'(CELL_ID)) begin
                        n_tag_vld  = 1'b1;
                        n_tag_addr = i_beat.addr;
                        n_tag_ptr  = i_beat.ptr;
                    end
                end
                CMD_INVALIDATE: begin
                    if (r_tag_vld && (r_tag_ptr == i_beat.ptr)) begin
                        n_tag_vld = 1'b0;
                    end
                end
                default: begin
                    n_tag_vld = r_tag_vld;
                end
            endcase
        end
    end

    // slot and stage registers, moving only when the chain advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld  <= 1'b0;
            r_beat.vld <= 1'b0;
        end else if (i_adv) begin
            r_tag_vld <= n_tag_vld;
            r_beat    <= n_beat;
        end
    end

    // payload without reset
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tag_addr <= n_tag_addr;
            r_tag_ptr  <= n_tag_ptr;
            r_slot     <= i_slot;
        end
    end

    assign o_beat = r_beat;
    assign o_slot = r_slot;

endmodule

@@ src/packet_tag_cam_round_robin_top.sv @@
// path: every cell adds its stage register between input beat and result beat
// throughput: one beat per cycle while the chain is not stalled; each command passes the slots in order, so
// back-to-back commands see each other's updates in the right order
// a held result stalls the whole chain, set by the single shared advance
// reset: synchronous, clears all slot valid marks, the victim counter and stage valid bits
module packet_tag_cam_round_robin_top #(
    parameter int NUM_TAGS = ptc_pkg::DEF_NUM_TAGS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [ptc_pkg::ADDR_W-1:0] i_address,
    input  logic [ptc_pkg::POS_W-1:0]  i_position,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_hit,
    output logic [ptc_pkg::PTR_W-1:0]  o_index
);
    import ptc_pkg::*;

    localparam int SLOT_W = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int POS_N  = 1 << POS_W;

    logic              w_adv;
    logic              w_acc;
    logic [SLOT_W-1:0] r_victim;
    logic [SLOT_W-1:0] n_victim;
    logic [PTR_W-1:0]  w_pos_tab [POS_N];
    t_beat             w_beat [NUM_TAGS+1];
    logic [SLOT_W-1:0] w_slot [NUM_TAGS+1];

    // position wrap table
    for (genvar gk = 0; gk < POS_N; gk++) begin : g_pos
        assign w_pos_tab[gk] = PTR_W'(gk % C_BUFFER_DEPTH);
    end

    // chain advances when the output stage is empty or being taken
    assign w_adv   = !w_beat[NUM_TAGS].vld || i_ready;
    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;

    // round-robin victim: advance first, then write that slot
    always_comb begin
        if (r_victim == SLOT_W'(NUM_TAGS - 1)) begin
            n_victim = '0;
        end else begin
            n_victim = r_victim + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_victim <= '0;
        end else if (w_acc && (t_cmd'(i_cmd) == CMD_SET_TAG)) begin
            r_victim <= n_victim;
        end
    end

    // head of the chain
    always_comb begin
        w_beat[0].vld   = i_valid;
        w_beat[0].cmd   = t_cmd'(i_cmd);
        w_beat[0].addr  = i_address;
        w_beat[0].ptr   = w_pos_tab[i_position];
        w_beat[0].hit   = 1'b0;
        w_beat[0].index = '0;
        w_slot[0]       = n_victim;
    end

    // row of tag cells
    for (genvar gi = 0; gi < NUM_TAGS; gi++) begin : g_cell
        ptc_cell #(
            .CELL_ID (gi),
            .SLOT_W  (SLOT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_beat  (w_beat[gi]),
            .i_slot  (w_slot[gi]),
            .o_beat  (w_beat[gi+1]),
            .o_slot  (w_slot[gi+1])
        );
    end

    // result beat
    assign o_valid = w_beat[NUM_TAGS].vld;
    assign o_hit   = w_beat[NUM_TAGS].hit;
    assign o_index = w_beat[NUM_TAGS].index;

    // victim counter stays inside the slot range
    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_victim) < NUM_TAGS))
        else $error("victim slot out of range");

    // only lookups report a hit
    a_hit_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (w_beat[NUM_TAGS].cmd != CMD_LOOKUP)) |-> !o_hit)
        else $error("hit on non-lookup beat");

    // a miss carries a zero index
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_index == '0))
        else $error("nonzero index on miss");

    // a stalled chain holds its first stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_beat[1]))
        else $error("chain moved while stalled");

    // victim counter moves only on an accepted set tag
    a_victim_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_acc && (t_cmd'(i_cmd) == CMD_SET_TAG)) |=> $stable(r_victim))
        else $error("victim moved without set tag");

endmodule
